[sv/byte_register_machine_core_unit_macros.svh]
// ----------------------------------------------------------------------------
// Byte register machine core - assertion macros
// Shared concurrent assertion forms, clocked with an active-low reset.
// ----------------------------------------------------------------------------
`ifndef BYTE_REGISTER_MACHINE_CORE_UNIT_MACROS_SVH
`define BYTE_REGISTER_MACHINE_CORE_UNIT_MACROS_SVH

// Same-cycle implication.
`define BRM_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define BRM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/brm_pkg.sv]
// ----------------------------------------------------------------------------
// brm_pkg
// Sizes, opcodes, controller/datapath interface types and the store index.
// ----------------------------------------------------------------------------
package brm_pkg;

  localparam int PROG_DEPTH = 256;
  localparam int REG_COUNT  = 16;
  localparam int PROG_AW    = $clog2(PROG_DEPTH);
  localparam int REG_AW     = $clog2(REG_COUNT);

  // reciprocal of the store depth, exact for every 8-bit address
  localparam int IDX_SHIFT = 16;
  localparam int IDX_RECIP = ((1 << IDX_SHIFT) + PROG_DEPTH - 1) / PROG_DEPTH;

  typedef enum logic [1:0] {
    OP_PWRITE  = 2'd0,
    OP_EXEC    = 2'd1,
    OP_RESTART = 2'd2
  } op_e;

  typedef enum logic [7:0] {
    OPC_LDI = 8'h04,
    OPC_DBL = 8'h05,
    OPC_JMP = 8'h07,
    OPC_JEF = 8'h0a,
    OPC_HLT = 8'h0b,
    OPC_SUB = 8'h0d,
    OPC_XOR = 8'h0e,
    OPC_OR  = 8'h0f,
    OPC_RD  = 8'h10,
    OPC_OUT = 8'h11
  } opc_e;

  typedef struct packed {
    logic load;    // latch the accepted item
    logic fetch;   // read opcode and operand from the store
    logic rdreg;   // read both register operands
    logic commit;  // update state and result register
  } ctrl_cmd_t;

  typedef struct packed {
    logic run;     // accepted item executes an instruction
  } dp_stat_t;

  // address modulo store depth: q = floor(a / depth) by reciprocal
  function automatic logic [PROG_AW-1:0] prog_idx(input logic [7:0] a);
    logic [31:0] q;
    logic [31:0] r;
    q = (32'(a) * 32'(IDX_RECIP)) >> IDX_SHIFT;
    r = 32'(a) - q * 32'(PROG_DEPTH);
    return r[PROG_AW-1:0];
  endfunction

endpackage

[sv/brm_in_if.sv]
// ----------------------------------------------------------------------------
// brm_in_if
// Input item channel: valid/ready handshake with the item fields.
// ----------------------------------------------------------------------------
interface brm_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] op;
  logic [7:0] prog_addr;
  logic [7:0] prog_byte;
  logic [7:0] data_byte;
  logic       data_present;

  modport source (
    output valid, op, prog_addr, prog_byte, data_byte, data_present,
    input  ready
  );
  modport sink (
    input  valid, op, prog_addr, prog_byte, data_byte, data_present,
    output ready
  );
endinterface

[sv/brm_out_if.sv]
// ----------------------------------------------------------------------------
// brm_out_if
// Result channel: valid/ready handshake with the result fields.
// ----------------------------------------------------------------------------
interface brm_out_if;
  logic       valid;
  logic       ready;
  logic       out_valid;
  logic [7:0] out_byte;
  logic       data_taken;
  logic       halted;
  logic       stuck;
  logic [7:0] pc_now;

  modport source (
    output valid, out_valid, out_byte, data_taken, halted, stuck, pc_now,
    input  ready
  );
  modport sink (
    input  valid, out_valid, out_byte, data_taken, halted, stuck, pc_now,
    output ready
  );
endinterface

[sv/brm_ctrl.sv]
// ----------------------------------------------------------------------------
// brm_ctrl
// Sequencer: accept, fetch, register read, execute/commit, result handoff.
// ----------------------------------------------------------------------------
module brm_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  output logic                  res_valid_o,
  input  logic                  res_ready_i,
  input  brm_pkg::dp_stat_t     stat_i,
  output brm_pkg::ctrl_cmd_t    cmd_o
);
  import brm_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FETCH,
    ST_RDREG,
    ST_EXEC
  } state_e;

  state_e state_q;
  logic   res_valid_q;
  logic   accept;
  logic   commit;

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  // result register may be refilled in the cycle its transfer completes
  assign commit     = (state_q == ST_EXEC) && (!res_valid_q || res_ready_i);

  assign cmd_o.load   = accept;
  assign cmd_o.fetch  = (state_q == ST_FETCH);
  assign cmd_o.rdreg  = (state_q == ST_RDREG);
  assign cmd_o.commit = commit;

  assign res_valid_o = res_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      res_valid_q <= 1'b0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            state_q <= stat_i.run ? ST_FETCH : ST_EXEC;
          end
        end
        ST_FETCH: state_q <= ST_RDREG;
        ST_RDREG: state_q <= ST_EXEC;
        ST_EXEC: begin
          if (commit) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase

      if (commit) begin
        res_valid_q <= 1'b1;
      end else if (res_ready_i) begin
        res_valid_q <= 1'b0;
      end
    end
  end

endmodule

[sv/brm_dp.sv]
// ----------------------------------------------------------------------------
// brm_dp
// Datapath: item latch, program store, register file, pc/flags, result reg.
// ----------------------------------------------------------------------------
module brm_dp (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  brm_pkg::ctrl_cmd_t    cmd_i,
  output brm_pkg::dp_stat_t     stat_o,
  input  logic [1:0]            op_i,
  input  logic [7:0]            prog_addr_i,
  input  logic [7:0]            prog_byte_i,
  input  logic [7:0]            data_byte_i,
  input  logic                  data_present_i,
  output logic                  out_valid_o,
  output logic [7:0]            out_byte_o,
  output logic                  data_taken_o,
  output logic                  halted_o,
  output logic                  stuck_o,
  output logic [7:0]            pc_now_o
);
  import brm_pkg::*;

  // latched item
  logic [1:0]          op_q;
  logic [7:0]          paddr_q;
  logic [7:0]          pbyte_q;
  logic [7:0]          dbyte_q;
  logic                dpres_q;

  // architectural state
  logic [7:0]          pc_q, pc_d;
  logic                end_q, end_d;
  logic                halt_q, halt_d;

  logic [7:0]          pmem [PROG_DEPTH];
  logic [7:0]          opc_q;
  logic [7:0]          opnd_q;
  logic                pm_we;

  logic [7:0]          rf_mem [REG_COUNT];
  logic [REG_COUNT-1:0] rf_vld_q;
  logic [7:0]          ra_q, rb_q;
  logic                ra_v_q, rb_v_q;
  logic [7:0]          ra, rb;
  logic [REG_AW-1:0]   lo, hi;
  logic                rf_we;
  logic [REG_AW-1:0]   rf_wa;
  logic [7:0]          rf_wd;

  // result
  logic                ovalid, taken, stuck;
  logic [7:0]          obyte;
  logic                res_ovalid_q, res_taken_q, res_halt_q, res_stuck_q;
  logic [7:0]          res_obyte_q, res_pc_q;

  assign stat_o.run = (op_i == OP_EXEC) && !halt_q;

  assign lo = opnd_q[REG_AW-1:0];
  assign hi = opnd_q[REG_AW +: REG_AW];
  // never-written registers read as their reset value
  assign ra = ra_v_q ? ra_q : 8'd0;
  assign rb = rb_v_q ? rb_q : 8'd0;

  always_comb begin
    pc_d   = pc_q;
    end_d  = end_q;
    halt_d = halt_q;
    pm_we  = 1'b0;
    rf_we  = 1'b0;
    rf_wa  = lo;
    rf_wd  = 8'd0;
    ovalid = 1'b0;
    obyte  = 8'd0;
    taken  = 1'b0;
    stuck  = 1'b0;
    case (op_q)
      OP_PWRITE: pm_we = 1'b1;
      OP_RESTART: begin
        pc_d   = 8'd0;
        end_d  = 1'b0;
        halt_d = 1'b0;
      end
      OP_EXEC: begin
        if (!halt_q) begin
          pc_d = pc_q + 8'd2;
          case (opc_q)
            OPC_LDI: begin
              rf_we = 1'b1;
              rf_wa = '0;
              rf_wd = opnd_q;
            end
            OPC_DBL: begin
              rf_we = 1'b1;
              rf_wd = {ra[6:0], 1'b0};
            end
            OPC_JMP: pc_d = pc_q + opnd_q;
            OPC_JEF: begin
              if (end_q) begin
                pc_d = pc_q + opnd_q;
              end
            end
            OPC_HLT: begin
              halt_d = 1'b1;
              pc_d   = pc_q;
            end
            OPC_SUB: begin
              rf_we = 1'b1;
              rf_wd = ra - rb;
            end
            OPC_XOR: begin
              rf_we = 1'b1;
              rf_wd = ra ^ rb;
            end
            OPC_OR: begin
              rf_we = 1'b1;
              rf_wd = ra | rb;
            end
            OPC_RD: begin
              if (dpres_q) begin
                rf_we = 1'b1;
                rf_wd = dbyte_q;
                end_d = 1'b0;
                taken = 1'b1;
              end else begin
                end_d = 1'b1;
              end
            end
            OPC_OUT: begin
              ovalid = 1'b1;
              obyte  = ra;
            end
            default: begin
              stuck = 1'b1;
              pc_d  = pc_q;
            end
          endcase
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q     <= 8'd0;
      end_q    <= 1'b0;
      halt_q   <= 1'b0;
      rf_vld_q <= '0;
    end else if (cmd_i.commit) begin
      pc_q   <= pc_d;
      end_q  <= end_d;
      halt_q <= halt_d;
      if (rf_we) begin
        rf_vld_q[rf_wa] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q    <= op_i;
      paddr_q <= prog_addr_i;
      pbyte_q <= prog_byte_i;
      dbyte_q <= data_byte_i;
      dpres_q <= data_present_i;
    end
    if (cmd_i.commit) begin
      res_ovalid_q <= ovalid;
      res_obyte_q  <= obyte;
      res_taken_q  <= taken;
      res_halt_q   <= halt_d;
      res_stuck_q  <= stuck;
      res_pc_q     <= pc_d;
    end
  end

  // program store: one write port, opcode and operand read ports
  always_ff @(posedge clk_i) begin
    if (cmd_i.commit && pm_we) begin
      pmem[prog_idx(paddr_q)] <= pbyte_q;
    end
    if (cmd_i.fetch) begin
      opc_q  <= pmem[prog_idx(pc_q)];
      opnd_q <= pmem[prog_idx(pc_q + 8'd1)];
    end
  end

  // register file: one write port, two read ports
  always_ff @(posedge clk_i) begin
    if (cmd_i.commit && rf_we) begin
      rf_mem[rf_wa] <= rf_wd;
    end
    if (cmd_i.rdreg) begin
      ra_q   <= rf_mem[lo];
      rb_q   <= rf_mem[hi];
      ra_v_q <= rf_vld_q[lo];
      rb_v_q <= rf_vld_q[hi];
    end
  end

  assign out_valid_o  = res_ovalid_q;
  assign out_byte_o   = res_obyte_q;
  assign data_taken_o = res_taken_q;
  assign halted_o     = res_halt_q;
  assign stuck_o      = res_stuck_q;
  assign pc_now_o     = res_pc_q;

endmodule

[sv/byte_register_machine_core_unit.sv]
// An executing item goes through fetch, register read and execute after its transfer;
//   others, execute while halted included, go straight to execute.
// A new item waits until the last has committed, at a pace set by the registered
//   program store read followed by the registered register file read.
// Reset clears pc, end flag, halt mark and register valid bits at once; the
//   program store holds no reset value and needs no clearing pass.
// ----------------------------------------------------------------------------
// byte_register_machine_core_unit
// 8-bit machine with 16 byte registers and a program store, one item at a time.
// ----------------------------------------------------------------------------
module byte_register_machine_core_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  brm_in_if.sink      in_i,
  brm_out_if.source   res_o
);
  import brm_pkg::*;

  ctrl_cmd_t cmd;
  dp_stat_t  stat;
  logic      in_ready;
  logic      res_valid;

  brm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_ready),
    .res_valid_o (res_valid),
    .res_ready_i (res_o.ready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  brm_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .op_i           (in_i.op),
    .prog_addr_i    (in_i.prog_addr),
    .prog_byte_i    (in_i.prog_byte),
    .data_byte_i    (in_i.data_byte),
    .data_present_i (in_i.data_present),
    .out_valid_o    (res_o.out_valid),
    .out_byte_o     (res_o.out_byte),
    .data_taken_o   (res_o.data_taken),
    .halted_o       (res_o.halted),
    .stuck_o        (res_o.stuck),
    .pc_now_o       (res_o.pc_now)
  );

  assign in_i.ready  = in_ready;
  assign res_o.valid = res_valid;

endmodule

[sv/brm_chk.sv]
// ----------------------------------------------------------------------------
// brm_chk
// Port-level checks on the machine core, bound to the top level.
// ----------------------------------------------------------------------------
`include "byte_register_machine_core_unit_macros.svh"

module brm_chk (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_i,
  input logic       res_valid_i,
  input logic       res_ready_i,
  input logic       out_valid_i,
  input logic [7:0] out_byte_i,
  input logic       data_taken_i,
  input logic       halted_i,
  input logic       stuck_i,
  input logic [7:0] pc_now_i
);

  logic [19:0] res_bits;
  logic        stall;
  logic        in_xfer;
  logic        stuck_res;
  logic        side_free;
  logic        no_out;

  assign res_bits  = {out_valid_i, out_byte_i, data_taken_i, halted_i, stuck_i, pc_now_i};
  assign stall     = res_valid_i && !res_ready_i;
  assign in_xfer   = in_valid_i && in_ready_i;
  assign stuck_res = res_valid_i && stuck_i;
  assign side_free = !halted_i && !out_valid_i && !data_taken_i;
  assign no_out    = res_valid_i && !out_valid_i;

  // a stalled result holds
  `BRM_ASSERT_NEXT(a_res_hold, clk_i, rst_ni, stall, res_valid_i && $stable(res_bits), "result moved")

  // one item in flight: no transfer right after a transfer
  `BRM_ASSERT_NEXT(a_one_item, clk_i, rst_ni, in_xfer, !in_ready_i, "input taken while busy")

  // an unknown opcode has no side effect and cannot come from a halted machine
  `BRM_ASSERT_NOW(a_stuck_quiet, clk_i, rst_ni, stuck_res, side_free, "stuck with side effect")

  // no byte is shown without the output instruction
  `BRM_ASSERT_NOW(a_obyte_zero, clk_i, rst_ni, no_out, out_byte_i == 8'd0, "out byte without output")

endmodule

bind byte_register_machine_core_unit brm_chk u_brm_chk (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_i.valid),
  .in_ready_i   (in_i.ready),
  .res_valid_i  (res_o.valid),
  .res_ready_i  (res_o.ready),
  .out_valid_i  (res_o.out_valid),
  .out_byte_i   (res_o.out_byte),
  .data_taken_i (res_o.data_taken),
  .halted_i     (res_o.halted),
  .stuck_i      (res_o.stuck),
  .pc_now_i     (res_o.pc_now)
);

[dv/byte_register_machine_core_unit_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// byte_register_machine_core_unit_tb
// Self-checking bench for the byte register machine. A short directed program
// walks through the main instructions and corner cases. Random episodes then
// load small programs and run them, mixed with stray writes, restarts and
// unused op items. A scoreboard predicts each result and checks it in order,
// while both channels see random gaps and stalls.
// ----------------------------------------------------------------------------
import brm_pkg::*;

typedef struct packed {
  logic [1:0] op;
  logic [7:0] prog_addr;
  logic [7:0] prog_byte;
  logic [7:0] data_byte;
  logic       data_present;
} brm_item_t;

typedef struct packed {
  logic       out_valid;
  logic [7:0] out_byte;
  logic       data_taken;
  logic       halted;
  logic       stuck;
  logic [7:0] pc_now;
} brm_result_t;

class machine_scoreboard;
  logic [7:0]  store [PROG_DEPTH];
  bit          written [PROG_DEPTH];
  logic [7:0]  regs [REG_COUNT];
  logic [7:0]  pc;
  logic        end_flag;
  logic        halt_mark;
  brm_result_t expected_q[$];
  int          mismatches;
  int          checked;
  int          n_exec;
  int          n_out;
  int          n_stuck;

  function new();
    for (int i = 0; i < PROG_DEPTH; i++) begin
      store[i]   = 8'h00;
      written[i] = 1'b0;
    end
    for (int i = 0; i < REG_COUNT; i++) regs[i] = 8'h00;
    pc        = 8'h00;
    end_flag  = 1'b0;
    halt_mark = 1'b0;
  endfunction

  function int slot(input logic [7:0] a);
    return int'(a) % PROG_DEPTH;
  endfunction

  function bit opc_known(input logic [7:0] c);
    case (c)
      OPC_LDI, OPC_DBL, OPC_JMP, OPC_JEF, OPC_HLT,
      OPC_SUB, OPC_XOR, OPC_OR, OPC_RD, OPC_OUT: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  // apply one accepted transfer to the machine state, queue its result
  function void note(input brm_item_t it);
    brm_result_t r;
    logic [7:0]  a;
    logic [7:0]  opc;
    logic [7:0]  b;
    logic [7:0]  nxt;
    logic [3:0]  lo;
    logic [3:0]  hi;
    r = '0;
    case (it.op)
      OP_PWRITE: begin
        store[slot(it.prog_addr)]   = it.prog_byte;
        written[slot(it.prog_addr)] = 1'b1;
      end
      OP_RESTART: begin
        pc        = 8'h00;
        end_flag  = 1'b0;
        halt_mark = 1'b0;
      end
      OP_EXEC: begin
        if (!halt_mark) begin
          a   = pc;
          opc = store[slot(a)];
          b   = store[slot(a + 8'd1)];
          lo  = b[3:0];
          hi  = b[7:4];
          nxt = a + 8'd2;
          n_exec++;
          case (opc)
            OPC_LDI: regs[0] = b;
            OPC_DBL: regs[lo] = {regs[lo][6:0], 1'b0};
            OPC_JMP: nxt = a + b;
            OPC_JEF: if (end_flag) nxt = a + b;
            OPC_HLT: begin
              halt_mark = 1'b1;
              nxt       = a;
            end
            OPC_SUB: regs[lo] = regs[lo] - regs[hi];
            OPC_XOR: regs[lo] = regs[lo] ^ regs[hi];
            OPC_OR:  regs[lo] = regs[lo] | regs[hi];
            OPC_RD: begin
              if (it.data_present) begin
                regs[lo]     = it.data_byte;
                end_flag     = 1'b0;
                r.data_taken = 1'b1;
              end else begin
                end_flag = 1'b1;
              end
            end
            OPC_OUT: begin
              r.out_byte  = regs[lo];
              r.out_valid = 1'b1;
              n_out++;
            end
            default: begin
              r.stuck = 1'b1;
              nxt     = a;
              n_stuck++;
            end
          endcase
          pc = nxt;
        end
      end
      default: ;
    endcase
    r.halted = halt_mark;
    r.pc_now = pc;
    expected_q.push_back(r);
  endfunction

  function void check(input brm_result_t got);
    brm_result_t e;
    if (expected_q.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("%0t: result with nothing pending: ov=%0b ob=%02h dt=%0b h=%0b st=%0b pc=%02h",
                 $realtime, got.out_valid, got.out_byte, got.data_taken, got.halted,
                 got.stuck, got.pc_now);
      return;
    end
    e = expected_q.pop_front();
    checked++;
    if (got.out_valid !== e.out_valid || got.out_byte !== e.out_byte ||
        got.data_taken !== e.data_taken || got.halted !== e.halted ||
        got.stuck !== e.stuck || got.pc_now !== e.pc_now) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("%0t: result %0d wrong", $realtime, checked);
        $display("  exp ov=%0b ob=%02h dt=%0b h=%0b st=%0b pc=%02h",
                 e.out_valid, e.out_byte, e.data_taken, e.halted, e.stuck, e.pc_now);
        $display("  got ov=%0b ob=%02h dt=%0b h=%0b st=%0b pc=%02h",
                 got.out_valid, got.out_byte, got.data_taken, got.halted, got.stuck,
                 got.pc_now);
      end
    end
  endfunction
endclass

module byte_register_machine_core_unit_tb;

  localparam logic [1:0] OP_UNUSED = 2'd3;

  logic clk_i;
  logic rst_ni;

  brm_in_if  in_if ();
  brm_out_if res_if ();

  byte_register_machine_core_unit uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .res_o  (res_if)
  );

  machine_scoreboard sb = new();
  int n_items;
  int n_results;
  int burst_left;
  bit hold_done;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #5_000_000;
    $display("Mismatches found");
    $finish;
  end

  // result side: random stall patterns drawn from four modes, plus one long hold-off
  initial begin : result_sink
    int cyc;
    int mode;
    cyc  = 0;
    mode = 0;
    res_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (!hold_done && n_results >= 150) begin
        hold_done = 1'b1;
        res_if.ready <= 1'b0;
        repeat (300) @(negedge clk_i);
      end
      if (cyc % 48 == 0) mode = $urandom_range(0, 3);
      cyc++;
      case (mode)
        0:       res_if.ready <= 1'b1;
        1:       res_if.ready <= ($urandom % 2 == 0);
        2:       res_if.ready <= ($urandom % 5 == 0);
        default: res_if.ready <= (cyc % 3 != 0);
      endcase
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && res_if.valid && res_if.ready) begin
      sb.check('{res_if.out_valid, res_if.out_byte, res_if.data_taken,
                 res_if.halted, res_if.stuck, res_if.pc_now});
      n_results++;
    end
  end

  function automatic brm_item_t noise_item(input logic [1:0] op);
    brm_item_t it;
    it.op           = op;
    it.prog_addr    = 8'($urandom);
    it.prog_byte    = 8'($urandom);
    it.data_byte    = 8'($urandom);
    it.data_present = 1'($urandom);
    return it;
  endfunction

  // called at a falling edge, returns at a falling edge after the transfer
  task automatic put(input brm_item_t it);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom % 4 == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_if.valid <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
    burst_left--;
    in_if.valid        <= 1'b1;
    in_if.op           <= it.op;
    in_if.prog_addr    <= it.prog_addr;
    in_if.prog_byte    <= it.prog_byte;
    in_if.data_byte    <= it.data_byte;
    in_if.data_present <= it.data_present;
    do @(posedge clk_i); while (in_if.ready !== 1'b1);
    sb.note(it);
    if (it.op != OP_UNUSED) n_items++;
    @(negedge clk_i);
  endtask

  task automatic write_byte(input logic [7:0] addr, input logic [7:0] val);
    brm_item_t it;
    it = noise_item(OP_PWRITE);
    it.prog_addr = addr;
    it.prog_byte = val;
    put(it);
  endtask

  task automatic exec_instr(input logic present, input logic [7:0] dbyte);
    brm_item_t it;
    it = noise_item(OP_EXEC);
    it.data_present = present;
    it.data_byte    = dbyte;
    put(it);
  endtask

  function automatic logic [7:0] pick_opcode();
    logic [7:0] codes [10];
    codes = '{OPC_LDI, OPC_DBL, OPC_JMP, OPC_JEF, OPC_HLT,
              OPC_SUB, OPC_XOR, OPC_OR, OPC_RD, OPC_OUT};
    if ($urandom % 100 < 6) return 8'($urandom);
    return codes[$urandom % 10];
  endfunction

  // jumps mostly land on an instruction boundary of the loaded program
  function automatic logic [7:0] pick_operand(input logic [7:0] opc, input int idx,
                                              input int len);
    int target;
    if ((opc == OPC_JMP || opc == OPC_JEF) && $urandom % 10 != 0) begin
      target = 2 * $urandom_range(0, len);
      return 8'(target - 2 * idx);
    end
    return 8'($urandom);
  endfunction

  // one item that keeps the machine running without fetching unwritten bytes
  task automatic step_machine();
    int         r;
    logic [7:0] pc;
    r  = $urandom % 100;
    pc = sb.pc;
    if (r < 5)
      put(noise_item(OP_UNUSED));
    else if (r < 9)
      write_byte(8'($urandom), 8'($urandom));
    else if (r < 11)
      put(noise_item(OP_RESTART));
    else if (sb.halt_mark) begin
      if ($urandom % 3 == 0) exec_instr(1'($urandom), 8'($urandom));
      else put(noise_item(OP_RESTART));
    end else if (!sb.written[sb.slot(pc)])
      write_byte(pc, pick_opcode());
    else if (!sb.written[sb.slot(pc + 8'd1)])
      write_byte(pc + 8'd1, 8'($urandom));
    else if (!sb.opc_known(sb.store[sb.slot(pc)]) && $urandom % 2 == 0)
      write_byte(pc, pick_opcode());
    else
      exec_instr($urandom % 8 != 0, 8'($urandom));
  endtask

  task automatic run_episode();
    int         len;
    int         steps;
    logic [7:0] opc;
    put(noise_item(OP_RESTART));
    len = $urandom_range(2, 8);
    for (int i = 0; i < len; i++) begin
      opc = pick_opcode();
      write_byte(8'(2 * i), opc);
      write_byte(8'(2 * i + 1), pick_operand(opc, i, len));
    end
    steps = $urandom_range(len, 3 * len);
    repeat (steps) step_machine();
  endtask

  initial begin : stimulus
    int  rand_start;
    bit  drained;
    drained            = 1'b0;
    in_if.valid        = 1'b0;
    in_if.op           = OP_PWRITE;
    in_if.prog_addr    = 8'h00;
    in_if.prog_byte    = 8'h00;
    in_if.data_byte    = 8'h00;
    in_if.data_present = 1'b0;
    rst_ni             = 1'b0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed: load, output, read at end of data, taken jump that wraps
    // below zero, halt, execute while halted, unused op, restart, unknown opcode
    write_byte(8'h00, OPC_LDI);
    write_byte(8'h01, 8'hFF);
    write_byte(8'h02, OPC_OUT);
    write_byte(8'h03, 8'h00);
    write_byte(8'h04, OPC_RD);
    write_byte(8'h05, 8'h25);
    write_byte(8'h06, OPC_JEF);
    write_byte(8'h07, 8'hF8);
    write_byte(8'hFE, OPC_HLT);
    write_byte(8'hFF, 8'h00);
    exec_instr(1'b1, 8'hFF);
    exec_instr(1'b1, 8'h00);
    exec_instr(1'b0, 8'hFF);
    exec_instr(1'b1, 8'h00);
    exec_instr(1'b1, 8'hFF);
    exec_instr(1'b0, 8'h00);
    put(noise_item(OP_UNUSED));
    put(noise_item(OP_RESTART));
    write_byte(8'h00, 8'hFF);
    exec_instr(1'b1, 8'hFF);
    exec_instr(1'b0, 8'h00);

    rand_start = n_items;
    while (n_items - rand_start < 600) begin
      run_episode();
      if (!drained && n_items - rand_start >= 300) begin
        // sender stops until every result is back
        drained = 1'b1;
        in_if.valid <= 1'b0;
        do @(negedge clk_i); while (sb.expected_q.size() != 0);
        burst_left = 0;
      end
    end

    in_if.valid <= 1'b0;
    do @(negedge clk_i); while (sb.expected_q.size() != 0);
    repeat (20) @(negedge clk_i);

    $display("Run: %0d items, %0d instructions executed, %0d bytes out, %0d unknown opcodes",
             n_items, sb.n_exec, sb.n_out, sb.n_stuck);
    $display("Checked %0d results under input gaps, output stalls and a long hold-off",
             sb.checked);
    if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
